>>> hdl/strong_probable_prime_test_core_macros.svh
// Assertion macros for the strong probable prime test core
`ifndef STRONG_PROBABLE_PRIME_TEST_CORE_MACROS_SVH
`define STRONG_PROBABLE_PRIME_TEST_CORE_MACROS_SVH
// implication checked every edge outside reset
`define SPPT_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
// next-cycle implication
`define SPPT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`endif

>>> hdl/sppt_pkg.sv
`timescale 1ns / 1ps
package sppt_pkg;
   localparam int NUMBER_BITS_DEF = 32;
   localparam logic [31:0] PSEUDO_EXCEPTION = 32'd3215031751;
   localparam int BASE_COUNT = 4;

   function automatic logic [2:0] base_value(input logic [1:0] idx);
      logic [2:0] v;
      case (idx)
         2'd0: v = 3'd2;
         2'd1: v = 3'd3;
         2'd2: v = 3'd5;
         default: v = 3'd7;
      endcase
      return v;
   endfunction

   // controller to datapath commands
   typedef enum logic [3:0] {
      OP_NONE  = 4'b0001,
      OP_LOAD  = 4'b0010,
      OP_BASE  = 4'b0100,
      OP_MUL   = 4'b1000
   } op_type;

   typedef struct packed {
      op_type     op;
      logic [1:0] base_idx;
      logic       sel_square;   // 1: x*x, 0: acc*sq
      logic       dest_acc;     // product written to acc, else sq
   } cmd_type;

   typedef struct packed {
      logic mul_done;
      logic trivial;      // result known without exponentiation
      logic trivial_prime;
      logic exp_bit;      // current exponent bit
      logic exp_last;     // no exponent bits left
      logic acc_is_one;
      logic acc_is_nm1;
      logic s_more;       // more squarings allowed
      logic is_exception;
   } stat_type;
endpackage

>>> hdl/sppt_datapath.sv
`timescale 1ns / 1ps
module sppt_datapath
   import sppt_pkg::*;
#(
   parameter int NUMBER_BITS = NUMBER_BITS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic [NUMBER_BITS-1:0] number,
   input  cmd_type                cmd,
   output stat_type               stat
);
   localparam int NB = NUMBER_BITS;
   localparam int CW = $clog2(2 * NB + 1);
   localparam int SW = $clog2(NB + 1);

   logic [NB-1:0] n_ff, d_ff, e_ff, acc_ff, sq_ff, m_ff;
   logic [NB-1:0] d_in, e_in, acc_in, sq_in, m_in;
   logic [SW-1:0] s_ff, s_in, k_ff, k_in;
   // shift-add modular multiplier: one multiplier bit a cycle, MSB first
   logic [NB-1:0] ma_ff, ma_in, mr_ff, mr_in;
   logic [CW-1:0] mc_ff, mc_in;
   logic          busy_ff, busy_in;
   logic          done_ff;
   logic [NB:0]   dbl, dbl_r, add, add_r;
   logic [NB-1:0] bval;
   logic [NB-1:0] nm1;
   logic [NB-1:0] prod;
   // residues mod 3/5/7, one bit of n folded in per idle cycle, MSB first
   logic [NB-1:0] rs_ff, rs_in;
   logic [2:0]    r3_ff, r3_in, r5_ff, r5_in, r7_ff, r7_in;
   logic [3:0]    t3, t5, t7;

   always_comb begin
      bval = NB'(base_value(cmd.base_idx));
      nm1  = n_ff - NB'(1);
      dbl  = {mr_ff, 1'b0};
      dbl_r = (dbl >= {1'b0, n_ff}) ? dbl - {1'b0, n_ff} : dbl;
      add  = dbl_r + (m_ff[NB-1] ? {1'b0, ma_ff} : '0);
      add_r = (add >= {1'b0, n_ff}) ? add - {1'b0, n_ff} : add;
      prod = mr_ff;
      t3   = {r3_ff, rs_ff[NB-1]};
      t5   = {r5_ff, rs_ff[NB-1]};
      t7   = {r7_ff, rs_ff[NB-1]};
   end

   always_comb begin
      d_in = d_ff; s_in = s_ff; e_in = e_ff; acc_in = acc_ff; sq_in = sq_ff;
      k_in = k_ff; ma_in = ma_ff; mr_in = mr_ff; m_in = m_ff;
      mc_in = mc_ff; busy_in = busy_ff;
      rs_in = rs_ff; r3_in = r3_ff; r5_in = r5_ff; r7_in = r7_ff;
      case (cmd.op)
         OP_LOAD: begin
            // n-1 = d*2^s: strip trailing zeros one per cycle
            d_in  = number - NB'(1);
            s_in  = '0;
            rs_in = number;
            r3_in = '0; r5_in = '0; r7_in = '0;
         end
         OP_BASE: begin
            e_in   = d_ff;
            acc_in = NB'(1);
            sq_in  = (bval >= n_ff) ? bval - n_ff : bval;
            k_in   = SW'(1);
         end
         OP_MUL: begin
            ma_in   = cmd.sel_square ? sq_ff : acc_ff;
            m_in    = sq_ff;
            if (cmd.dest_acc && cmd.sel_square) begin
               ma_in = acc_ff; m_in = acc_ff;
            end
            mr_in   = '0;
            mc_in   = CW'(NB);
            busy_in = 1'b1;
         end
         default: begin
            if (d_ff != '0 && !d_ff[0]) begin
               d_in = d_ff >> 1;
               s_in = s_ff + SW'(1);
            end
            // folds past the last bit keep zero residues zero, others nonzero
            rs_in = rs_ff << 1;
            r3_in = (t3 >= 4'd3) ? 3'(t3 - 4'd3) : 3'(t3);
            r5_in = (t5 >= 4'd5) ? 3'(t5 - 4'd5) : 3'(t5);
            r7_in = (t7 >= 4'd7) ? 3'(t7 - 4'd7) : 3'(t7);
         end
      endcase
      if (busy_ff) begin
         mr_in = add_r[NB-1:0];
         m_in  = m_ff << 1;
         mc_in = mc_ff - CW'(1);
         if (mc_ff == CW'(1)) busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= busy_ff && (mc_ff == CW'(1));
      end
      d_ff <= d_in; s_ff <= s_in; ma_ff <= ma_in; mr_ff <= mr_in;
      m_ff <= m_in; mc_ff <= mc_in;
      rs_ff <= rs_in; r3_ff <= r3_in; r5_ff <= r5_in; r7_ff <= r7_in;
      if (cmd.op == OP_LOAD) n_ff <= number;
      // write-back of the finished product
      if (done_ff && cmd.op == OP_NONE) begin
         if (cmd.dest_acc) begin
            acc_ff <= prod;
            if (cmd.sel_square) k_ff <= k_ff + SW'(1);
         end else begin
            sq_ff <= prod;
            e_ff  <= e_ff >> 1;
         end
      end else begin
         e_ff <= e_in; acc_ff <= acc_in; sq_ff <= sq_in; k_ff <= k_in;
      end
   end

   logic [NB-1:0] n_in_v;
   always_comb begin
      n_in_v = n_ff;
      stat.mul_done      = done_ff;
      stat.exp_bit       = e_ff[0];
      stat.exp_last      = (e_ff == '0);
      stat.acc_is_one    = (acc_ff == NB'(1));
      stat.acc_is_nm1    = (acc_ff == nm1);
      stat.s_more        = (k_ff < s_ff);
      stat.is_exception  = (NB == 32) && (32'(n_ff) == PSEUDO_EXCEPTION);
      stat.trivial_prime = (n_in_v == NB'(2)) || (n_in_v == NB'(3)) ||
                           (n_in_v == NB'(5)) || (n_in_v == NB'(7));
      stat.trivial = (n_in_v < NB'(2)) || stat.trivial_prime || !n_in_v[0] ||
                     (r3_ff == 3'd0) || (r5_ff == 3'd0) || (r7_ff == 3'd0);
   end
endmodule

>>> hdl/sppt_control.sv
`timescale 1ns / 1ps
module sppt_control
   import sppt_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     start,
   output logic     busy,
   input  stat_type stat,
   output cmd_type  cmd,
   output logic     rsp_valid,
   output logic     rsp_is_prime
);
   typedef enum logic [8:0] {
      ST_IDLE   = 9'b0_0000_0001,
      ST_SPLIT  = 9'b0_0000_0010,
      ST_BASE   = 9'b0_0000_0100,
      ST_STEP   = 9'b0_0000_1000,
      ST_WAIT   = 9'b0_0001_0000,
      ST_CHECK  = 9'b0_0010_0000,
      ST_SQWAIT = 9'b0_0100_0000,
      ST_DONE   = 9'b0_1000_0000,
      ST_SQ     = 9'b1_0000_0000
   } state_type;

   state_type  state_ff, state_in;
   logic [1:0] base_ff, base_in;
   logic [5:0] split_ff, split_in;
   logic       accmul_ff, accmul_in;
   logic       result_ff, result_in;
   logic       sq_ff, sq_in;

   always_comb begin
      state_in = state_ff; base_in = base_ff; split_in = split_ff;
      accmul_in = accmul_ff; result_in = result_ff; sq_in = sq_ff;
      cmd = '{op: OP_NONE, base_idx: base_ff, sel_square: sq_ff, dest_acc: accmul_ff};
      case (state_ff)
         ST_IDLE: if (start) begin
            cmd.op = OP_LOAD; split_in = '0; state_in = ST_SPLIT;
         end
         ST_SPLIT: begin
            // trailing-zero strip and residue folding
            split_in = split_ff + 6'd1;
            if (split_ff == 6'd34) begin
               if (stat.trivial) begin
                  result_in = stat.trivial_prime; state_in = ST_DONE;
               end else begin
                  base_in = '0; state_in = ST_BASE;
               end
            end
         end
         ST_BASE: begin
            cmd.op = OP_BASE; state_in = ST_STEP;
         end
         ST_STEP: begin
            sq_in = 1'b0;
            if (stat.exp_last) state_in = ST_CHECK;
            else if (stat.exp_bit) begin
               // acc*sq when bit set, then sq*sq
               accmul_in = 1'b1;
               cmd.op = OP_MUL; cmd.sel_square = 1'b0; cmd.dest_acc = 1'b1;
               state_in = ST_WAIT;
            end else begin
               accmul_in = 1'b0; state_in = ST_SQ;
            end
         end
         ST_SQ: begin
            // sq*sq, written back with the exponent shift
            accmul_in = 1'b0;
            cmd.op = OP_MUL; cmd.sel_square = 1'b1; cmd.dest_acc = 1'b0;
            state_in = ST_WAIT;
         end
         ST_WAIT: if (stat.mul_done) begin
            if (accmul_ff) begin
               accmul_in = 1'b0; state_in = ST_SQ;
            end else state_in = ST_STEP;
         end
         ST_CHECK: begin
            if ((stat.acc_is_one && sq_ff == 1'b0) || stat.acc_is_nm1) begin
               sq_in = 1'b0;
               if (base_ff == 2'(BASE_COUNT - 1)) begin
                  result_in = !stat.is_exception; state_in = ST_DONE;
               end else begin
                  base_in = base_ff + 2'd1; state_in = ST_BASE;
               end
            end else if (stat.s_more) begin
               sq_in = 1'b1; accmul_in = 1'b1;
               cmd.op = OP_MUL; cmd.sel_square = 1'b1; cmd.dest_acc = 1'b1;
               state_in = ST_SQWAIT;
            end else begin
               sq_in = 1'b0; result_in = 1'b0; state_in = ST_DONE;
            end
         end
         ST_SQWAIT: if (stat.mul_done) state_in = ST_CHECK;
         ST_DONE: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE; sq_ff <= 1'b0; accmul_ff <= 1'b0;
      end else begin
         state_ff <= state_in; sq_ff <= sq_in; accmul_ff <= accmul_in;
      end
      base_ff <= base_in; split_ff <= split_in; result_ff <= result_in;
   end

   assign busy         = (state_ff != ST_IDLE);
   assign rsp_valid    = (state_ff == ST_DONE);
   assign rsp_is_prime = result_ff;
endmodule

>>> hdl/strong_probable_prime_test_core.sv
`timescale 1ns / 1ps
// Numbers the small checks settle are answered straight after the split phase; others
// go through the exponentiation for up to four bases, paced by the bit-serial modular
// multiplier.
// Throughput: one number at a time; next start taken the cycle after the strobe.
// Result: rsp_valid pulses one cycle; the receiver cannot stall.
// Reset: synchronous, active high; clears the controller to idle.
module strong_probable_prime_test_core
   import sppt_pkg::*;
#(
   parameter int NUMBER_BITS = NUMBER_BITS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  logic [NUMBER_BITS-1:0] req_number,
   output logic                   rsp_valid,
   output logic                   rsp_is_prime
);
   cmd_type  cmd;
   stat_type stat;

   // controller sequences split, per-base exponentiation and strong check
   sppt_control u_ctrl (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .stat(stat), .cmd(cmd), .rsp_valid(rsp_valid), .rsp_is_prime(rsp_is_prime)
   );

   // datapath holds n, d, s and the shift-add modular multiplier
   sppt_datapath #(.NUMBER_BITS(NUMBER_BITS)) u_dp (
      .clock(clock), .reset(reset), .number(req_number), .cmd(cmd), .stat(stat)
   );
endmodule

>>> hdl/sppt_checker.sv
`timescale 1ns / 1ps
`include "strong_probable_prime_test_core_macros.svh"
module sppt_checker (
   input logic clock,
   input logic reset,
   input logic start,
   input logic busy,
   input logic rsp_valid
);
   `SPPT_ASSERT_NEXT(a_start_busy, clock, reset, start && !busy, busy)
   `SPPT_ASSERT_IMP(a_valid_busy, clock, reset, rsp_valid, busy)
   `SPPT_ASSERT_NEXT(a_valid_pulse, clock, reset, rsp_valid, !rsp_valid && !busy)
endmodule

bind strong_probable_prime_test_core sppt_checker u_chk (
   .clock(clock), .reset(reset), .start(start), .busy(busy), .rsp_valid(rsp_valid)
);
